>>> rtl/twr_pkg.sv
package twr_pkg;

  // command codes carried by the action field
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // position inside one outgoing bit: data set, clock high, clock low
  typedef enum logic [1:0] {
    BIT_SET  = 2'd0,
    BIT_RISE = 2'd1,
    BIT_FALL = 2'd2
  } bit_pos_e;

  localparam int unsigned StepW = 6;

  localparam logic [StepW-1:0] DRIVE_PHASE      = 6'd2;
  localparam logic [StepW-1:0] ADDR_FIRST_PHASE = 6'd3;
  localparam logic [StepW-1:0] ADDR_LAST_PHASE  = 6'd26;
  localparam logic [StepW-1:0] TURN_PHASE       = 6'd27;
  localparam logic [StepW-1:0] DATA_FIRST_PHASE = 6'd28;
  localparam logic [StepW-1:0] LAST_READ_PHASE  = 6'd44;
  localparam logic [StepW-1:0] LAST_WRITE_PHASE = 6'd52;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic             is_read;
    bit_pos_e         bit_pos;
    logic [7:0]       shift_out;
    logic [7:0]       data_hold;
    logic [7:0]       shift_in;
    logic [7:0]       phase_count;
    logic             ce;
    logic             sclk;
    logic             dout;
    logic             drive;
  } seq_state_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

endpackage

>>> rtl/three_wire_register_access_master_unit.sv
// Three-wire serial register access master (chip enable, serial clock,
// bidirectional data). Each input item is either a tick of time or a
// write/read command; every accepted item yields exactly one result item
// with the line levels, busy/done flags, the read shift register and a
// rejected flag for commands that arrive mid-transaction. Throughput is one
// item per clock while the result register is free: an item waits in the
// input register while the sequencer step logic works out the next state, and
// is loaded into the result register once that register is empty or being
// taken. The result register decouples the two sides; the input side only
// stalls when the result register is full and not being taken. Each phase of
// the sequence lasts phase_ticks tick items (0 acts as 1), written through
// cfg_we_i/cfg_wdata_i; the user must write it only while the unit is idle,
// as the unit itself does not enforce this.
module three_wire_register_access_master_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: phase length in ticks
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // input item channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic       io_in_i,
  // result item channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       chip_enable_o,
  output logic       serial_clock_o,
  output logic       io_out_o,
  output logic       io_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_data_o,
  output logic       rejected_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [1:0] action_q;
  logic [7:0] address_q;
  logic [7:0] write_data_q;
  logic       io_in_q;

  // sequencer state and configuration
  twr_pkg::seq_state_t state_q, state_d;
  logic [7:0]          phase_ticks_q;

  // result register
  logic             out_valid_q, out_valid_d;
  twr_pkg::result_t res_q, res_d;

  logic accept_in;
  logic advance;

  // item moves from the input register into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept_in  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  twr_step u_step (
    .cur_i         (state_q),
    .action_i      (action_q),
    .address_i     (address_q),
    .write_data_i  (write_data_q),
    .io_in_i       (io_in_q),
    .phase_ticks_i (phase_ticks_q),
    .nxt_o         (state_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_ticks_q <= 8'd1;
      state_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      action_q     <= action_i;
      address_q    <= address_i;
      write_data_q <= write_data_i;
      io_in_q      <= io_in_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chip_enable_o  = res_q.chip_enable;
  assign serial_clock_o = res_q.serial_clock;
  assign io_out_o       = res_q.io_out;
  assign io_drive_o     = res_q.io_drive;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign read_data_o    = res_q.read_data;
  assign rejected_o     = res_q.rejected;

endmodule

>>> rtl/twr_step.sv
module twr_step (
  input  twr_pkg::seq_state_t cur_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          address_i,
  input  logic [7:0]          write_data_i,
  input  logic                io_in_i,
  input  logic [7:0]          phase_ticks_i,
  output twr_pkg::seq_state_t nxt_o,
  output twr_pkg::result_t    res_o
);

  twr_pkg::seq_state_t nxt;
  logic [8:0]              cnt;
  logic [7:0]              len;
  logic [twr_pkg::StepW-1:0] np;
  logic [twr_pkg::StepW-1:0] last;
  logic                    busy;
  logic                    done;
  logic                    rej;
  logic                    send;

  always_comb begin
    nxt  = cur_i;
    done = 1'b0;
    rej  = 1'b0;
    send = 1'b0;
    busy = (cur_i.step != '0);
    len  = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
    cnt  = {1'b0, cur_i.phase_count} + 9'd1;
    np   = cur_i.step + 6'd1;
    last = cur_i.is_read ? twr_pkg::LAST_READ_PHASE : twr_pkg::LAST_WRITE_PHASE;

    unique case (twr_pkg::action_e'(action_i))
      twr_pkg::ACT_WRITE, twr_pkg::ACT_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          nxt.is_read     = (twr_pkg::action_e'(action_i) == twr_pkg::ACT_READ);
          nxt.shift_out   = address_i;
          nxt.data_hold   = write_data_i;
          nxt.phase_count = 8'd0;
          nxt.step        = 6'd1;
          nxt.ce          = 1'b1;
        end
      end
      twr_pkg::ACT_TICK: begin
        if (busy) begin
          if (cnt >= {1'b0, len}) begin
            nxt.phase_count = 8'd0;
            if (cur_i.step >= last) begin
              nxt.step = '0;
              done     = 1'b1;
            end else begin
              nxt.step = np;
              // sub-position of the entered phase within its bit
              if (np == twr_pkg::ADDR_FIRST_PHASE || np == twr_pkg::DATA_FIRST_PHASE) begin
                nxt.bit_pos = twr_pkg::BIT_SET;
              end else begin
                unique case (cur_i.bit_pos)
                  twr_pkg::BIT_SET:  nxt.bit_pos = twr_pkg::BIT_RISE;
                  twr_pkg::BIT_RISE: nxt.bit_pos = twr_pkg::BIT_FALL;
                  default:           nxt.bit_pos = twr_pkg::BIT_SET;
                endcase
              end
              priority if (np == twr_pkg::DRIVE_PHASE) begin
                nxt.drive = 1'b1;
              end else if (np <= twr_pkg::ADDR_LAST_PHASE) begin
                send = 1'b1;
              end else if (np == twr_pkg::TURN_PHASE) begin
                if (cur_i.is_read) begin
                  nxt.drive = 1'b0;
                end else begin
                  nxt.drive     = 1'b1;
                  nxt.shift_out = cur_i.data_hold;
                end
              end else if (cur_i.is_read) begin
                if (np < twr_pkg::LAST_READ_PHASE) begin
                  if (!np[0]) begin
                    nxt.shift_in = {io_in_i, cur_i.shift_in[7:1]};
                    nxt.sclk     = 1'b1;
                  end else begin
                    nxt.sclk = 1'b0;
                  end
                end else begin
                  nxt.ce = 1'b0;
                end
              end else begin
                if (np < twr_pkg::LAST_WRITE_PHASE) begin
                  send = 1'b1;
                end else begin
                  nxt.ce = 1'b0;
                end
              end
              if (send) begin
                unique case (nxt.bit_pos)
                  twr_pkg::BIT_SET:  nxt.dout = cur_i.shift_out[0];
                  twr_pkg::BIT_RISE: nxt.sclk = 1'b1;
                  default: begin
                    nxt.sclk      = 1'b0;
                    nxt.shift_out = {1'b0, cur_i.shift_out[7:1]};
                  end
                endcase
              end
            end
          end else begin
            nxt.phase_count = cnt[7:0];
          end
        end
      end
      default: begin
        nxt = cur_i;
      end
    endcase
  end

  assign nxt_o = nxt;

  assign res_o.chip_enable  = nxt.ce;
  assign res_o.serial_clock = nxt.sclk;
  assign res_o.io_out       = nxt.dout;
  assign res_o.io_drive     = nxt.drive;
  assign res_o.busy_res     = (nxt.step != '0);
  assign res_o.done_res     = done;
  assign res_o.read_data    = nxt.shift_in;
  assign res_o.rejected     = rej;

endmodule
